FILE: design/rls_pkg.sv
package rls_pkg;

  localparam int unsigned WINDOW_DEF = 64;
  localparam int unsigned NS_PER_US  = 1000;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned US_W       = 32;
  localparam int unsigned MEAN_W     = 48;

  // ceil(2^30 / 125): x / 1000 == ((x >> 3) * US_RECIP) >> 30 for x below 2^26
  localparam logic [23:0] US_RECIP   = 24'd8589935;

  // request to the shared divider
  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  // request to the window sorter
  typedef struct packed {
    logic            go;
    logic [US_W-1:0] sample;
  } sort_req_t;

  typedef struct packed {
    logic            done;
    logic [US_W-1:0] median;
  } sort_rsp_t;

endpackage

FILE: design/rolling_latency_statistics.sv
// rolling latency statistics: each input beat carries one duration in ns.
// it is turned into whole us (divide by 1000, low 32 bits), folded into a
// running mean (Q32.16) and M2 (Q56.8, saturating), and written into a ring
// of the last WINDOW samples whose sorted copy gives the median. one result
// beat comes out per input beat. an item goes through a reciprocal
// conversion of ns to us (four 16-bit chunks), two passes of the shared
// one-bit-per-cycle divider (mean step, M2 over count-1), a shift-add
// multiply and a square root; the first sample skips the variance path.
// the sorted window update runs beside the arithmetic, paced by the
// registered read of its memory. in_stall is high from the accepted beat
// until its result is loaded into the output register.
module rolling_latency_statistics #(
  parameter int unsigned WINDOW = rls_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_duration_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_last_us,
  output logic [47:0] out_mean_us_q16,
  output logic [31:0] out_win_median,
  output logic [35:0] out_stddev_us_q4,
  output logic [63:0] out_sample_count
);

  localparam int unsigned MW = rls_pkg::MEAN_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_US,
    ST_MLD,
    ST_STEP,
    ST_D2,
    ST_MUL,
    ST_M2,
    ST_VARL,
    ST_VAR,
    ST_SQRT,
    ST_JOIN
  } top_state_t;

  top_state_t         state_r;
  rls_pkg::div_req_t  div_req_r;
  rls_pkg::sort_req_t sort_req_r;
  rls_pkg::sort_rsp_t sort_rsp;
  logic               div_done;
  logic [63:0]        div_quo;
  logic               sort_done_r;

  logic [63:0]        cnt_r;
  logic [MW-1:0]      mean_r;
  logic [63:0]        m2_r;
  logic [31:0]        us_r;
  logic               neg_r;
  logic [MW-1:0]      mag_r;

  // ns to us conversion, 16 bits of the duration per chunk
  logic [63:0]        cv_ns_r;
  logic [9:0]         cv_rem_r;
  logic [15:0]        cv_q_r;
  logic [1:0]         cv_cnt_r;
  logic               cv_ph_r;

  // shift-add multiplier
  logic [2*MW-1:0]    macc_r;
  logic [2*MW-1:0]    mcand_r;
  logic [MW-1:0]      mplier_r;
  logic [5:0]         mcnt_r;

  // bit-pair square root
  logic [63:0]        sq_v_r;
  logic [63:0]        sq_res_r;
  logic [63:0]        sq_bit_r;
  logic [4:0]         sq_cnt_r;
  logic [31:0]        sd_r;

  logic               out_valid_r;
  logic [31:0]        out_last_r;
  logic [MW-1:0]      out_mean_r;
  logic [31:0]        out_median_r;
  logic [35:0]        out_sd_r;
  logic [63:0]        out_cnt_r;

  logic [25:0]        cv_v;
  logic [46:0]        cv_prod;
  logic [MW-1:0]      x_cur;
  logic [MW-1:0]      d2;
  logic [63:0]        term;
  logic [64:0]        m2_sum;
  logic [63:0]        sq_sum;
  logic               sq_ge;
  logic [63:0]        sq_res_nxt;

  rls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  rls_sorter #(
    .WINDOW (WINDOW)
  ) u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sort_req_r),
    .rsp   (sort_rsp)
  );

  assign in_stall = state_r != ST_IDLE;

  // remainder so far with the next 16 bits, always below 1000 * 2^16
  assign cv_v    = {cv_rem_r, cv_ns_r[63:48]};
  assign cv_prod = 47'(cv_v[25:3]) * 47'(rls_pkg::US_RECIP);

  // sample in Q32.16 as held
  assign x_cur = {us_r, 16'h0000};
  assign d2    = (x_cur >= mean_r) ? x_cur - mean_r : mean_r - x_cur;

  // product is Q32, keep Q8; anything above 64 bits saturates
  assign term   = (macc_r[2*MW-1:88] != '0) ? '1 : macc_r[87:24];
  assign m2_sum = {1'b0, m2_r} + {1'b0, term};

  assign sq_sum     = sq_res_r + sq_bit_r;
  assign sq_ge      = sq_v_r >= sq_sum;
  assign sq_res_nxt = sq_ge ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      div_req_r.go   <= 1'b0;
      sort_req_r.go  <= 1'b0;
      sort_done_r    <= 1'b0;
      cnt_r          <= '0;
      mean_r         <= '0;
      m2_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      div_req_r.go  <= 1'b0;
      sort_req_r.go <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (sort_rsp.done) sort_done_r <= 1'b1;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cv_ns_r  <= in_duration_ns;
            cv_rem_r <= '0;
            cv_cnt_r <= '0;
            cv_ph_r  <= 1'b0;
            if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
            sort_done_r   <= 1'b0;
            state_r       <= ST_US;
          end
        end
        ST_US: begin
          // quotient digit by reciprocal, then the remainder on the next cycle
          if (!cv_ph_r) begin
            cv_q_r  <= 16'(cv_prod >> 30);
            cv_ph_r <= 1'b1;
          end else begin
            cv_rem_r <= 10'(cv_v - 26'(cv_q_r) * 26'(rls_pkg::NS_PER_US));
            cv_ns_r  <= cv_ns_r << 16;
            us_r     <= {us_r[15:0], cv_q_r};
            cv_ph_r  <= 1'b0;
            cv_cnt_r <= cv_cnt_r + 1'b1;
            if (cv_cnt_r == 2'd3) state_r <= ST_MLD;
          end
        end
        ST_MLD: begin
          sort_req_r.go     <= 1'b1;
          sort_req_r.sample <= us_r;
          neg_r             <= x_cur < mean_r;
          mag_r             <= (x_cur < mean_r) ? mean_r - x_cur : x_cur - mean_r;
          div_req_r.go      <= 1'b1;
          div_req_r.num     <= (x_cur < mean_r) ? 64'(mean_r - x_cur)
                                                : 64'(x_cur - mean_r);
          div_req_r.den     <= cnt_r;
          state_r           <= ST_STEP;
        end
        ST_STEP: begin
          if (div_done) begin
            mean_r  <= neg_r ? mean_r - div_quo[MW-1:0] : mean_r + div_quo[MW-1:0];
            state_r <= ST_D2;
          end
        end
        ST_D2: begin
          macc_r   <= '0;
          mcand_r  <= {{MW{1'b0}}, mag_r};
          mplier_r <= d2;
          mcnt_r   <= '0;
          state_r  <= ST_MUL;
        end
        ST_MUL: begin
          if (mplier_r[0]) macc_r <= macc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          mcnt_r   <= mcnt_r + 1'b1;
          if (mcnt_r == 6'(MW - 1)) state_r <= ST_M2;
        end
        ST_M2: begin
          m2_r <= m2_sum[64] ? '1 : m2_sum[63:0];
          if (cnt_r > 64'd1) begin
            state_r <= ST_VARL;
          end else begin
            sd_r    <= '0;
            state_r <= ST_JOIN;
          end
        end
        ST_VARL: begin
          div_req_r.go  <= 1'b1;
          div_req_r.num <= m2_r;
          div_req_r.den <= cnt_r - 1'b1;
          state_r       <= ST_VAR;
        end
        ST_VAR: begin
          if (div_done) begin
            sq_v_r   <= div_quo;
            sq_res_r <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            sq_cnt_r <= '0;
            state_r  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_ge) sq_v_r <= sq_v_r - sq_sum;
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'd31) begin
            sd_r    <= sq_res_nxt[31:0];
            state_r <= ST_JOIN;
          end
        end
        ST_JOIN: begin
          // wait for the median and a free output register
          if ((sort_done_r || sort_rsp.done) && (!out_valid_r || !out_stall)) begin
            out_valid_r  <= 1'b1;
            out_last_r   <= us_r;
            out_mean_r   <= mean_r;
            out_median_r <= sort_rsp.median;
            out_sd_r     <= {4'h0, sd_r};
            out_cnt_r    <= cnt_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_last_us      = out_last_r;
  assign out_mean_us_q16  = out_mean_r;
  assign out_win_median   = out_median_r;
  assign out_stddev_us_q4 = out_sd_r;
  assign out_sample_count = out_cnt_r;

endmodule

FILE: design/rls_div.sv
module rls_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rls_pkg::div_req_t           req,
  output logic                        done,
  output logic [rls_pkg::DIV_W-1:0]   quo
);

  localparam int unsigned W  = rls_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.num;
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: design/rls_sorter.sv
module rls_sorter #(
  parameter int unsigned WINDOW = rls_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rls_pkg::sort_req_t  req,
  output rls_pkg::sort_rsp_t  rsp
);

  localparam int unsigned IW = $clog2(WINDOW);
  localparam int unsigned FW = $clog2(WINDOW + 1);
  localparam int unsigned DW = rls_pkg::US_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OLD,
    S_RD,
    S_DEC
  } sort_state_t;

  logic [DW-1:0] ring_mem [WINDOW];
  logic [DW-1:0] bank0_mem [WINDOW];
  logic [DW-1:0] bank1_mem [WINDOW];

  sort_state_t   state_r;
  logic [IW-1:0] wp_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fnew_r;
  logic          bank_r;
  logic          full_r;
  logic          ins_r;
  logic          skp_r;
  logic [FW-1:0] rd_r;
  logic [FW-1:0] wr_r;
  logic [DW-1:0] new_v_r;
  logic [DW-1:0] old_v_r;
  logic [DW-1:0] ring_rd_r;
  logic [DW-1:0] b0_rd_r;
  logic [DW-1:0] b1_rd_r;
  logic [DW-1:0] mid_lo_r;
  logic [DW-1:0] mid_hi_r;
  logic [DW-1:0] median_r;
  logic          done_r;

  logic [IW-1:0] rd_addr;
  logic [DW-1:0] elem;
  logic          elem_ok;
  logic          wr_en;
  logic [DW-1:0] wr_val;
  logic [FW-1:0] mid_lo_idx;
  logic [FW-1:0] mid_hi_idx;
  logic [DW:0]   mid_sum;

  assign elem_ok    = rd_r < fill_r;
  assign rd_addr    = elem_ok ? rd_r[IW-1:0] : '0;
  assign elem       = bank_r ? b1_rd_r : b0_rd_r;
  assign mid_lo_idx = (fnew_r - 1'b1) >> 1;
  assign mid_hi_idx = fnew_r >> 1;
  assign mid_sum    = {1'b0, mid_lo_r} + {1'b0, mid_hi_r};

  // merge step: drop one copy of the evicted value, insert the new one
  always_comb begin
    wr_en  = 1'b0;
    wr_val = elem;
    if (state_r == S_DEC && wr_r != fnew_r) begin
      if (full_r && !skp_r && elem_ok && elem == old_v_r) begin
        wr_en = 1'b0;
      end else if (!ins_r && (!elem_ok || elem > new_v_r)) begin
        wr_en  = 1'b1;
        wr_val = new_v_r;
      end else begin
        wr_en  = 1'b1;
        wr_val = elem;
      end
    end
  end

  // bank reads registered each cycle; bank writes into the idle bank
  always_ff @(posedge clk) begin
    b0_rd_r <= bank0_mem[rd_addr];
    b1_rd_r <= bank1_mem[rd_addr];
    if (state_r == S_IDLE && req.go) begin
      ring_rd_r      <= ring_mem[wp_r];
      ring_mem[wp_r] <= req.sample;
    end
    if (wr_en) begin
      if (bank_r) bank0_mem[wr_r[IW-1:0]] <= wr_val;
      else        bank1_mem[wr_r[IW-1:0]] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      bank_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (wr_en) begin
        if (wr_r == mid_lo_idx) mid_lo_r <= wr_val;
        if (wr_r == mid_hi_idx) mid_hi_r <= wr_val;
      end
      case (state_r)
        S_IDLE: begin
          if (req.go) begin
            new_v_r <= req.sample;
            full_r  <= fill_r == FW'(WINDOW);
            fnew_r  <= (fill_r == FW'(WINDOW)) ? fill_r : fill_r + 1'b1;
            wp_r    <= (wp_r == IW'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
            rd_r    <= '0;
            wr_r    <= '0;
            ins_r   <= 1'b0;
            skp_r   <= 1'b0;
            state_r <= S_OLD;
          end
        end
        S_OLD: begin
          old_v_r <= ring_rd_r;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (wr_r == fnew_r) begin
            fill_r   <= fnew_r;
            bank_r   <= !bank_r;
            median_r <= mid_sum[DW:1];
            done_r   <= 1'b1;
            state_r  <= S_IDLE;
          end else if (!wr_en) begin
            skp_r   <= 1'b1;
            rd_r    <= rd_r + 1'b1;
            state_r <= S_RD;
          end else if (wr_val == new_v_r && !ins_r && (!elem_ok || elem > new_v_r)) begin
            ins_r   <= 1'b1;
            wr_r    <= wr_r + 1'b1;
          end else begin
            rd_r    <= rd_r + 1'b1;
            wr_r    <= wr_r + 1'b1;
            state_r <= S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.median = median_r;

endmodule
